>>> hdl/mpetm_pkg.sv
`timescale 1ns / 1ps
package mpetm_pkg;

  localparam int LEVELS_W = 16;
  localparam int TS_W     = 32;
  localparam int IDX_W    = 4;
  localparam int STAT_W   = 32;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0] PIN_COUNT_RESET = 5'd16;

  typedef struct packed {
    logic [LEVELS_W-1:0] pin_levels;
    logic [TS_W-1:0]     timestamp;
  } sample_t;

  typedef struct packed {
    logic [IDX_W-1:0]  pin_index;
    logic              new_level;
    logic [STAT_W-1:0] low_total;
    logic [STAT_W-1:0] high_total;
    logic [STAT_W-1:0] shortest_low;
    logic [STAT_W-1:0] change_count;
    logic              last_of_run;
  } result_t;

  typedef logic [CFG_W-1:0] cfg_t;

endpackage

>>> hdl/mpetm_chan_if.sv
`timescale 1ns / 1ps
interface mpetm_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/mpetm_ram.sv
`timescale 1ns / 1ps
module mpetm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read returns the old word on a same-address write
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/multi_pin_edge_timing_monitor.sv
`timescale 1ns / 1ps
// Edge timing monitor for up to sixteen pins.
// sample (sink): pin_levels and timestamp of one sample, taken on valid && ready.
// result (source): one item per monitored pin that changed, lowest pin first,
//   last_of_run set on the final item of a sample.
// cfg (sink): pin_count, always ready; write only while the block is idle.
// Per-pin statistics live in one RAM word per pin (last edge time, low and high
// totals, shortest low time, edge count); each edge reads its word, updates it
// and writes it back, with the previous write forwarded on a same-pin read.
// The first item of a sample passes the pending edge list, the RAM read, the update
// stage and the output register. One result item per cycle while the receiver takes
// them; a new sample is accepted as the last pending edge of the old one is issued.
// A sample with no reported edge still updates the stored levels and emits nothing.
// Reset clears the levels, sets pin_count to 16 and marks every RAM word invalid;
// an invalid word reads as zero with the shortest low time all ones.
// When the receiver stalls, the output register holds its item, the update
// stage waits, and a new sample is taken only while the pending edge list is empty.
module multi_pin_edge_timing_monitor
  import mpetm_pkg::*;
#(
  parameter int PIN_COUNT  = 16,
  parameter int TIME_WIDTH = 32
) (
  input  logic  clk,
  input  logic  rst,
  mpetm_chan_if.sink   sample,
  mpetm_chan_if.source result,
  mpetm_chan_if.sink   cfg
);

  localparam int LANES = (PIN_COUNT < LEVELS_W) ? PIN_COUNT : LEVELS_W;
  localparam int PIN_W = (LANES > 1) ? $clog2(LANES) : 1;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] last_edge;
    logic [TIME_WIDTH-1:0] low_acc;
    logic [TIME_WIDTH-1:0] high_acc;
    logic [TIME_WIDTH-1:0] min_low;
    logic [TIME_WIDTH-1:0] edges;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
  localparam entry_t ENTRY_RESET = '{last_edge: '0, low_acc: '0, high_acc: '0,
                                     min_low: '1, edges: '0};

  logic [CFG_W-1:0]      pin_count;
  logic [LEVELS_W-1:0]   prev_levels;
  logic [LANES-1:0]      watch_mask;
  logic [LANES-1:0]      pending;
  logic [LANES-1:0]      pending_rest;
  logic [LANES-1:0]      issue_bit;
  logic [PIN_W-1:0]      issue_pin;
  logic [LANES-1:0]      job_levels;
  logic [TIME_WIDTH-1:0] job_now;
  logic                  issue;
  logic                  sample_fire;
  logic                  out_free;
  logic                  adv;

  logic                  m_valid;
  logic                  m_fire;
  logic [PIN_W-1:0]      m_pin;
  logic                  m_level;
  logic [TIME_WIDTH-1:0] m_now;
  logic                  m_last;
  logic                  m_hit;

  logic [LANES-1:0]      entry_valid;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic                  wr_en_q;
  logic [PIN_W-1:0]      wr_addr_q;
  entry_t                wr_data_q;
  entry_t                cur;
  entry_t                upd;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [TIME_WIDTH:0]   low_sum;
  logic [TIME_WIDTH:0]   high_sum;

  logic                  out_valid;
  result_t               out_q;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_count <= PIN_COUNT_RESET;
    end else if (cfg.valid) begin
      pin_count <= cfg.data;
    end
  end

  // edge detection and pending edge list
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      watch_mask[i] = (sample.data.pin_levels[i] ^ prev_levels[i]) &&
                      (CFG_W'(i) < pin_count);
    end
  end

  assign issue_bit    = pending & (~pending + LANES'(1));
  assign pending_rest = pending & ~issue_bit;

  always_comb begin
    issue_pin = '0;
    for (int i = 0; i < LANES; i++) begin
      if (issue_bit[i]) begin
        issue_pin = PIN_W'(i);
      end
    end
  end

  assign out_free     = !out_valid || result.ready;
  assign m_fire       = m_valid && out_free;
  assign adv          = !m_valid || out_free;
  assign issue        = adv && (pending != '0);
  assign sample.ready = (pending == '0) || (issue && (pending_rest == '0));
  assign sample_fire  = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= '0;
      prev_levels <= '0;
    end else if (sample_fire) begin
      pending     <= watch_mask;
      prev_levels <= sample.data.pin_levels;
    end else if (issue) begin
      pending     <= pending_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_fire) begin
      job_levels <= sample.data.pin_levels[LANES-1:0];
      job_now    <= TIME_WIDTH'(sample.data.timestamp);
    end
  end

  // update stage, fed by the RAM read issued with the pin that it now holds
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      m_pin   <= issue_pin;
      m_level <= job_levels[issue_pin];
      m_now   <= job_now;
      m_last  <= (pending_rest == '0);
      m_hit   <= entry_valid[issue_pin];
    end
  end

  mpetm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LANES)
  ) u_stat_ram (
    .clk   (clk),
    .we    (m_fire),
    .waddr (m_pin),
    .wdata (upd),
    .re    (issue),
    .raddr (issue_pin),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (m_fire) begin
      entry_valid[m_pin] <= 1'b1;
    end
  end

  // hold the last write; it coincided with the read now in the update stage
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_en_q <= 1'b0;
    end else if (adv) begin
      wr_en_q <= m_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (m_fire) begin
      wr_addr_q <= m_pin;
      wr_data_q <= upd;
    end
  end

  always_comb begin
    if (wr_en_q && (wr_addr_q == m_pin)) begin
      cur = wr_data_q;
    end else if (m_hit) begin
      cur = entry_t'(ram_rdata);
    end else begin
      cur = ENTRY_RESET;
    end
  end

  assign elapsed  = m_now - cur.last_edge;
  assign low_sum  = {1'b0, cur.low_acc} + {1'b0, elapsed};
  assign high_sum = {1'b0, cur.high_acc} + {1'b0, elapsed};

  always_comb begin
    upd = cur;
    if (m_level) begin
      upd.low_acc = low_sum[TIME_WIDTH] ? '1 : low_sum[TIME_WIDTH-1:0];
      if (elapsed < cur.min_low) begin
        upd.min_low = elapsed;
      end
    end else begin
      upd.high_acc = high_sum[TIME_WIDTH] ? '1 : high_sum[TIME_WIDTH-1:0];
    end
    upd.edges     = cur.edges + TIME_WIDTH'(1);
    upd.last_edge = m_now;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (m_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (m_fire) begin
      out_q.pin_index    <= IDX_W'(m_pin);
      out_q.new_level    <= m_level;
      out_q.low_total    <= STAT_W'(upd.low_acc);
      out_q.high_total   <= STAT_W'(upd.high_acc);
      out_q.shortest_low <= STAT_W'(upd.min_low);
      out_q.change_count <= STAT_W'(upd.edges);
      out_q.last_of_run  <= m_last;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_q;

`ifndef ASSERT_OFF
  a_no_read_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_valid && !out_free) |-> !issue)
    else $error("RAM read issued while the update stage is stalled");

  a_written_entry_valid: assert property (@(posedge clk) disable iff (rst)
    m_fire |=> entry_valid[wr_addr_q])
    else $error("written entry not marked valid");

  a_accept_drains_list: assert property (@(posedge clk) disable iff (rst)
    sample_fire |-> ((pending == '0) || (issue && (pending_rest == '0))))
    else $error("sample accepted while edges are still pending");

  a_issue_one_pin: assert property (@(posedge clk) disable iff (rst)
    issue |-> $onehot(issue_bit))
    else $error("issue does not select exactly one pin");
`endif

endmodule

>>> tb/sv/tb_multi_pin_edge_timing_monitor.sv
`timescale 1ns / 1ps
module tb_multi_pin_edge_timing_monitor;
  import mpetm_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int NUM_PINS     = 16;

  logic clk;
  logic rst;

  mpetm_chan_if #(.T(sample_t)) sample_if ();
  mpetm_chan_if #(.T(result_t)) result_if ();
  mpetm_chan_if #(.T(cfg_t))    cfg_if ();

  multi_pin_edge_timing_monitor dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  // Shadow copy of the per-pin statistics
  cfg_t              pin_count_q;
  logic [15:0]       prev_levels;
  logic [STAT_W-1:0] last_edge_ts [NUM_PINS];
  logic [STAT_W-1:0] low_acc      [NUM_PINS];
  logic [STAT_W-1:0] high_acc     [NUM_PINS];
  logic [STAT_W-1:0] min_low      [NUM_PINS];
  logic [STAT_W-1:0] edge_cnt     [NUM_PINS];

  result_t     edge_reports_q [$];
  int          mismatches;
  int          cycle_count;
  int          src_idle_pct;
  int          snk_idle_pct;
  int          stall_request;
  logic [31:0] ts_cursor;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL multi_pin_edge_timing_monitor");
      $finish;
    end
  end

  // Receiver: random ready, or a long hold-off when requested
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall_request) @(posedge clk);
        stall_request = 0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic reset_stats();
    pin_count_q = PIN_COUNT_RESET;
    prev_levels = '0;
    for (int i = 0; i < NUM_PINS; i++) begin
      last_edge_ts[i] = '0;
      low_acc[i]      = '0;
      high_acc[i]     = '0;
      min_low[i]      = '1;
      edge_cnt[i]     = '0;
    end
  endtask

  task automatic predict_edges(input logic [15:0] lv, input logic [31:0] ts);
    logic [15:0]       changed;
    logic [STAT_W-1:0] elapsed;
    logic [STAT_W:0]   sum;
    result_t           rec;
    int                last_pin;
    changed  = lv ^ prev_levels;
    last_pin = -1;
    for (int i = 0; i < NUM_PINS; i++)
      if (i < pin_count_q && changed[i]) last_pin = i;
    for (int i = 0; i < NUM_PINS; i++) begin
      if (i < pin_count_q && changed[i]) begin
        elapsed = ts - last_edge_ts[i];
        if (lv[i]) begin
          sum        = {1'b0, low_acc[i]} + elapsed;
          low_acc[i] = sum[STAT_W] ? '1 : sum[STAT_W-1:0];
          if (elapsed < min_low[i]) min_low[i] = elapsed;
        end else begin
          sum         = {1'b0, high_acc[i]} + elapsed;
          high_acc[i] = sum[STAT_W] ? '1 : sum[STAT_W-1:0];
        end
        edge_cnt[i]     = edge_cnt[i] + 1;
        last_edge_ts[i] = ts;
        rec.pin_index    = i[IDX_W-1:0];
        rec.new_level    = lv[i];
        rec.low_total    = low_acc[i];
        rec.high_total   = high_acc[i];
        rec.shortest_low = min_low[i];
        rec.change_count = edge_cnt[i];
        rec.last_of_run  = (i == last_pin);
        edge_reports_q.push_back(rec);
      end
    end
    prev_levels = lv;
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (edge_reports_q.size() == 0) begin
      $error("unexpected result item: pin_index %0d", got.pin_index);
      mismatches++;
      return;
    end
    want = edge_reports_q.pop_front();
    if (got.pin_index !== want.pin_index) begin
      $error("pin_index expected %0d actual %0d", want.pin_index, got.pin_index);
      mismatches++;
    end
    if (got.new_level !== want.new_level) begin
      $error("new_level expected %0d actual %0d", want.new_level, got.new_level);
      mismatches++;
    end
    if (got.low_total !== want.low_total) begin
      $error("low_total expected %h actual %h", want.low_total, got.low_total);
      mismatches++;
    end
    if (got.high_total !== want.high_total) begin
      $error("high_total expected %h actual %h", want.high_total, got.high_total);
      mismatches++;
    end
    if (got.shortest_low !== want.shortest_low) begin
      $error("shortest_low expected %h actual %h", want.shortest_low, got.shortest_low);
      mismatches++;
    end
    if (got.change_count !== want.change_count) begin
      $error("change_count expected %h actual %h", want.change_count, got.change_count);
      mismatches++;
    end
    if (got.last_of_run !== want.last_of_run) begin
      $error("last_of_run expected %0d actual %0d", want.last_of_run, got.last_of_run);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_if.valid === 1'b1 && result_if.ready === 1'b1)
      check_result(result_if.data);
  end

  task automatic send_sample(input logic [15:0] lv, input logic [31:0] ts);
    sample_t s;
    while ($urandom_range(99) < src_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk);
    end
    s.pin_levels = lv;
    s.timestamp  = ts;
    sample_if.valid <= 1'b1;
    sample_if.data  <= s;
    do @(posedge clk); while (sample_if.ready !== 1'b1);
    predict_edges(lv, ts);
  endtask

  // Hold the sender until every expected item has come and the pipe is empty
  task automatic wait_idle();
    sample_if.valid <= 1'b0;
    do @(posedge clk); while (edge_reports_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_pin_count(input cfg_t value);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    pin_count_q = value;
  endtask

  task automatic send_random_sample();
    logic [15:0] lv;
    int          kind;
    int          step;
    kind = $urandom_range(99);
    if (kind < 55) begin
      lv = prev_levels ^ (16'd1 << $urandom_range(15));
      if ($urandom_range(1)) lv = lv ^ (16'd1 << $urandom_range(15));
    end else if (kind < 75) begin
      lv = 16'($urandom);
    end else if (kind < 85) begin
      lv = prev_levels;
    end else begin
      lv = ~prev_levels;
    end
    step = $urandom_range(99);
    if (step < 5)       ts_cursor = ts_cursor;
    else if (step < 85) ts_cursor = ts_cursor + $urandom_range(1, 60);
    else if (step < 97) ts_cursor = ts_cursor + $urandom_range(0, 1 << 20);
    else                ts_cursor = $urandom;
    send_sample(lv, ts_cursor);
  endtask

  task automatic test_edges_and_saturation();
    send_sample(16'h0000, 32'd5);          // no change, nothing reported
    send_sample(16'hffff, 32'd100);        // first edges, measured from zero
    send_sample(16'h0000, 32'hffffffff);
    send_sample(16'h0001, 32'd3);          // elapsed wraps around
    send_sample(16'h0003, 32'hfffffffe);   // low total saturates on pin 1
    send_sample(16'h0001, 32'hfffffffd);   // high total saturates on pin 1
    send_sample(16'h0000, 32'hfffffffd);
    send_sample(16'h0001, 32'hfffffffd);   // zero-length low period
    send_sample(16'haaaa, 32'h00001000);
    send_sample(16'h5555, 32'h00001001);
    send_sample(16'h5555, 32'h00002000);
    send_sample(16'h8000, 32'h80000000);
    wait_idle();
    ts_cursor = 32'h80000000;
  endtask

  task automatic test_pin_count_limits();
    write_pin_count(5'd0);                 // nothing monitored
    send_sample(~prev_levels, ts_cursor + 10);
    send_sample(16'h1234, ts_cursor + 20);
    write_pin_count(5'd1);
    send_sample(prev_levels ^ 16'h0003, ts_cursor + 30);
    send_sample(prev_levels ^ 16'h0003, ts_cursor + 45);
    write_pin_count(5'd8);
    send_sample(prev_levels ^ 16'hff00, ts_cursor + 60);  // unmonitored pins only
    send_sample(~prev_levels, ts_cursor + 70);
    write_pin_count(5'd31);                // acts as sixteen
    send_sample(~prev_levels, ts_cursor + 90);
    send_sample(~prev_levels, ts_cursor + 95);
    write_pin_count(5'd16);
    send_sample(~prev_levels, ts_cursor + 200);
    wait_idle();
    ts_cursor = ts_cursor + 200;
  endtask

  task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                     input cfg_t first_cfg, input cfg_t second_cfg);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    write_pin_count(first_cfg);
    repeat (55) send_random_sample();
    // pause until drained, then change the pin count
    write_pin_count(second_cfg);
    repeat (55) send_random_sample();
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_pin_count(5'd16);
    stall_request = 300;
    repeat (40) begin
      ts_cursor = ts_cursor + $urandom_range(1, 30);
      send_sample(~prev_levels, ts_cursor);
    end
    wait_idle();
  endtask

  initial begin
    rst             = 1'b1;
    sample_if.valid = 1'b0;
    sample_if.data  = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    mismatches      = 0;
    cycle_count     = 0;
    src_idle_pct    = 0;
    snk_idle_pct    = 0;
    stall_request   = 0;
    ts_cursor       = '0;
    reset_stats();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_edges_and_saturation();
    test_pin_count_limits();
    test_random_traffic(34, 82, 5'd16, cfg_t'($urandom_range(1, 15)));
    test_random_traffic(82, 34, cfg_t'($urandom_range(0, 31)), 5'd1);
    test_random_traffic(0, 0, cfg_t'($urandom_range(17, 31)), cfg_t'($urandom_range(0, 16)));
    test_output_backpressure();

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS multi_pin_edge_timing_monitor");
    end else begin
      $display("FAIL multi_pin_edge_timing_monitor");
    end
    $finish;
  end

endmodule
